### hdl/lcabl_pkg.sv
// Shared constants and types for the binary-lifting common ancestor block.
// No dependencies; imported by the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package lcabl_pkg;

    // Width of every node, depth and count field.
    localparam int FIELD_W = 10;
    // Node storage covers every index that a node field can hold.
    localparam int NODE_W  = FIELD_W;
    localparam int NODES   = 1 << NODE_W;
    // Number of power-of-two ancestor rows.
    localparam int LEVELS  = 10;
    localparam int LVL_W   = $clog2(LEVELS);

    // Packed stream widths, padded to whole bytes.
    localparam int S_DATA_W = ((3 * FIELD_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((FIELD_W + 7) / 8) * 8;

    typedef logic [FIELD_W-1:0] t_node;
    typedef logic [LVL_W-1:0]   t_level;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_BUILD = 2'd1,
        ACT_QUERY = 2'd2
    } t_action;

endpackage

`default_nettype wire

### hdl/lcabl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; instanced for the ancestor rows and the depth store.
`timescale 1ns / 1ps
`default_nettype none

module lcabl_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/lca_binary_lifting.sv
// Top level of the lowest common ancestor block using binary lifting.
// Depends on lcabl_pkg and lcabl_ram (one RAM per ancestor row plus the depth store).
//
//   channel   direction  signals                               contents
//   s (in)    slave      i_s_tvalid o_s_tready i_s_tdata/tuser action, two nodes, depth
//   m (out)   master     o_m_tvalid i_m_tready o_m_tdata/tuser ancestor, answer flag
//   cfg       slave      i_cfg_valid o_cfg_ready i_cfg_data    node_count register
//
// After reset a clearing pass writes zero to every node address of all rows and of the depth
// store, one address per cycle; items wait meanwhile, configuration writes do not. A load item
// writes its parent and depth when the node is in range; an unknown action goes straight to the
// result. A query passes the accept, the depth reads and the swap, the lift over every row with
// a further read per jump, an equality check, the joint climb over every row, the parent read and
// the result. A build fills rows 1 to 9 up to node_count. A waiting result lets the next item in.
`timescale 1ns / 1ps
`default_nettype none

module lca_binary_lifting (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Input item stream.
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // tdata from bit 0 up: node_first[9:0], node_second[19:10], node_depth[29:20], zero.
    input  wire logic [lcabl_pkg::S_DATA_W-1:0]   i_s_tdata,
    // tuser from bit 0 up: action[1:0].
    input  wire logic [1:0]                       i_s_tuser,
    // Result item stream.
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // tdata from bit 0 up: ancestor[9:0], zero.
    output logic      [lcabl_pkg::M_DATA_W-1:0]   o_m_tdata,
    // tuser from bit 0 up: is_answer[0].
    output logic      [0:0]                       o_m_tuser,
    // Configuration write channel for node_count.
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [lcabl_pkg::FIELD_W-1:0]    i_cfg_data
);

    import lcabl_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_B_CHK,
        S_B_RD1,
        S_B_RD2,
        S_B_WR,
        S_Q_RDA,
        S_Q_RDB,
        S_Q_SWAP,
        S_Q_L1,
        S_Q_L1B,
        S_Q_L1D,
        S_Q_EQ,
        S_Q_L2A,
        S_Q_L2B,
        S_Q_L2C,
        S_Q_FIN,
        S_Q_ANS,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [NODE_W-1:0]   r_clr_addr;
    t_node               r_node_count;

    // Working registers of the sequencer.
    t_node               r_a;
    t_node               r_b;
    t_node               r_da;
    t_node               r_db;
    t_node               r_ua;
    t_node               r_depth;
    t_node               r_ans;
    logic                r_is_ans;
    logic                r_load_ok;
    t_level              r_lvl;
    logic [NODE_W:0]     r_n;
    t_level              r_rd_lvl;

    // Result register.
    logic                r_o_valid;
    t_node               r_o_anc;
    logic                r_o_is_ans;

    // RAM controls.
    logic                tbl_we;
    t_level              tbl_wlvl;
    logic [NODE_W-1:0]   tbl_waddr;
    t_node               tbl_wdata;
    logic [NODE_W-1:0]   tbl_raddr;
    t_level              rd_lvl;
    logic                dep_we;
    logic [NODE_W-1:0]   dep_raddr;
    t_node               tbl_rdata [LEVELS];
    t_node               tbl_q;
    t_node               dep_q;
    logic                clearing;

    // Shared subtractor: depth of the second node minus depth of the first.
    t_node               sub_lhs;
    logic [FIELD_W:0]    gap;
    logic                gap_neg;
    logic                jump;

    logic                s_accept;
    logic                out_free;
    logic                build_end;

    assign clearing   = (r_state == S_CLEAR);
    assign o_s_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_o_valid || i_m_tready;

    assign tbl_q   = tbl_rdata[r_rd_lvl];
    assign sub_lhs = (r_state == S_Q_SWAP) ? dep_q : r_db;
    assign gap     = {1'b0, sub_lhs} - {1'b0, r_da};
    assign gap_neg = gap[FIELD_W];
    // A lift at this row happens only while the depth gap is at least 2^row.
    assign jump    = !gap_neg && (gap[FIELD_W-1:0] >= (FIELD_W'(1) << r_lvl));

    assign build_end = (r_n > {1'b0, r_node_count});

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {{(M_DATA_W - FIELD_W){1'b0}}, r_o_anc};
    assign o_m_tuser  = r_o_is_ans;

    // Read and write addressing of the stores for each sequencer step.
    always_comb begin
        tbl_we    = 1'b0;
        tbl_wlvl  = '0;
        tbl_waddr = r_n[NODE_W-1:0];
        tbl_wdata = tbl_q;
        tbl_raddr = r_b;
        rd_lvl    = r_lvl;
        dep_we    = 1'b0;
        dep_raddr = r_b;
        unique case (r_state)
            S_LOAD: begin
                tbl_we    = r_load_ok;
                tbl_waddr = r_a;
                tbl_wdata = r_b;
                dep_we    = r_load_ok;
            end
            S_B_RD1: begin
                rd_lvl    = LVL_W'(r_lvl - 1'b1);
                tbl_raddr = r_n[NODE_W-1:0];
            end
            S_B_RD2: begin
                rd_lvl    = LVL_W'(r_lvl - 1'b1);
                tbl_raddr = tbl_q;
            end
            S_B_WR: begin
                tbl_we   = 1'b1;
                tbl_wlvl = r_lvl;
            end
            S_Q_RDA: begin
                dep_raddr = r_a;
            end
            S_Q_L1B: begin
                dep_raddr = tbl_q;
            end
            S_Q_L2A: begin
                tbl_raddr = r_a;
            end
            S_Q_FIN: begin
                tbl_raddr = r_a;
                rd_lvl    = '0;
            end
            default: begin
            end
        endcase
    end

    // One RAM per ancestor row; the clearing pass writes zero to all of them at once.
    for (genvar g = 0; g < LEVELS; g++) begin : g_row
        logic row_we;
        assign row_we = clearing || (tbl_we && (tbl_wlvl == LVL_W'(g)));
        lcabl_ram #(
            .WIDTH (FIELD_W),
            .DEPTH (NODES)
        ) u_row (
            .i_clk   (i_clk),
            .i_we    (row_we),
            .i_waddr (clearing ? r_clr_addr : tbl_waddr),
            .i_wdata (clearing ? t_node'(0) : tbl_wdata),
            .i_raddr (tbl_raddr),
            .o_rdata (tbl_rdata[g])
        );
    end

    lcabl_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (NODES)
    ) u_depth (
        .i_clk   (i_clk),
        .i_we    (clearing || dep_we),
        .i_waddr (clearing ? r_clr_addr : r_a),
        .i_wdata (clearing ? t_node'(0) : r_depth),
        .i_raddr (dep_raddr),
        .o_rdata (dep_q)
    );

    always_ff @(posedge i_clk) begin
        r_rd_lvl <= rd_lvl;
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_node_count <= t_node'(1);
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_node_count <= i_cfg_data;
            end
            // The output register fills from the done step and empties when its item is taken.
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == NODE_W'(NODES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_accept) begin
                        r_a       <= i_s_tdata[FIELD_W-1:0];
                        r_b       <= i_s_tdata[2*FIELD_W-1:FIELD_W];
                        r_depth   <= i_s_tdata[3*FIELD_W-1:2*FIELD_W];
                        r_load_ok <= (i_s_tdata[FIELD_W-1:0] != '0)
                                  && (i_s_tdata[FIELD_W-1:0] <= r_node_count);
                        r_ans     <= '0;
                        r_is_ans  <= 1'b0;
                        r_lvl     <= t_level'(1);
                        r_n       <= (NODE_W+1)'(1);
                        unique case (t_action'(i_s_tuser))
                            ACT_LOAD:  r_state <= S_LOAD;
                            ACT_BUILD: r_state <= S_B_CHK;
                            ACT_QUERY: r_state <= S_Q_RDA;
                            default:   r_state <= S_DONE;
                        endcase
                    end
                end
                S_LOAD: begin
                    r_state <= S_DONE;
                end
                S_B_CHK: begin
                    if (build_end) begin
                        if (r_lvl == LVL_W'(LEVELS - 1)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_lvl <= r_lvl + 1'b1;
                            r_n   <= (NODE_W+1)'(1);
                        end
                    end else begin
                        r_state <= S_B_RD1;
                    end
                end
                S_B_RD1: begin
                    r_state <= S_B_RD2;
                end
                S_B_RD2: begin
                    r_state <= S_B_WR;
                end
                S_B_WR: begin
                    r_n     <= r_n + 1'b1;
                    r_state <= S_B_CHK;
                end
                S_Q_RDA: begin
                    r_state <= S_Q_RDB;
                end
                S_Q_RDB: begin
                    r_da    <= dep_q;
                    r_state <= S_Q_SWAP;
                end
                S_Q_SWAP: begin
                    // Keep the shallower node in r_a.
                    if (gap_neg) begin
                        r_a  <= r_b;
                        r_b  <= r_a;
                        r_da <= dep_q;
                        r_db <= r_da;
                    end else begin
                        r_db <= dep_q;
                    end
                    r_lvl   <= LVL_W'(LEVELS - 1);
                    r_state <= S_Q_L1;
                end
                S_Q_L1: begin
                    if (jump) begin
                        r_state <= S_Q_L1B;
                    end else if (r_lvl == '0) begin
                        r_state <= S_Q_EQ;
                    end else begin
                        r_lvl <= r_lvl - 1'b1;
                    end
                end
                S_Q_L1B: begin
                    r_b     <= tbl_q;
                    r_state <= S_Q_L1D;
                end
                S_Q_L1D: begin
                    r_db <= dep_q;
                    if (r_lvl == '0) begin
                        r_state <= S_Q_EQ;
                    end else begin
                        r_lvl   <= r_lvl - 1'b1;
                        r_state <= S_Q_L1;
                    end
                end
                S_Q_EQ: begin
                    r_is_ans <= 1'b1;
                    if (r_a == r_b) begin
                        r_ans   <= r_a;
                        r_state <= S_DONE;
                    end else begin
                        r_lvl   <= LVL_W'(LEVELS - 1);
                        r_state <= S_Q_L2A;
                    end
                end
                S_Q_L2A: begin
                    r_state <= S_Q_L2B;
                end
                S_Q_L2B: begin
                    r_ua    <= tbl_q;
                    r_state <= S_Q_L2C;
                end
                S_Q_L2C: begin
                    if (r_ua != tbl_q) begin
                        r_a <= r_ua;
                        r_b <= tbl_q;
                    end
                    if (r_lvl == '0) begin
                        r_state <= S_Q_FIN;
                    end else begin
                        r_lvl   <= r_lvl - 1'b1;
                        r_state <= S_Q_L2A;
                    end
                end
                S_Q_FIN: begin
                    r_state <= S_Q_ANS;
                end
                S_Q_ANS: begin
                    r_ans   <= tbl_q;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_anc    <= r_ans;
                        r_o_is_ans <= r_is_ans;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Acknowledgments of loads, builds and unknown actions always carry ancestor zero.
    a_ack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("acknowledgment carries a nonzero ancestor");

    // The block is busy in the cycle after it takes an item.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_tready)
        else $error("item accepted while the previous one is still in work");

    // The clearing pass ends only after the last node address has been written.
    a_clear_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_CLEAR && r_state != S_CLEAR)
            |-> ($past(r_clr_addr) == NODE_W'(NODES - 1)))
        else $error("clearing pass ended early");

    // No result is shown before the stores are cleared.
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_m_tvalid)
        else $error("result shown during the clearing pass");

endmodule

`default_nettype wire

### tb/tb_lca_binary_lifting.sv
// Self-checking testbench for lca_binary_lifting: random trees are loaded, built and
// queried over the item streams, and each result is checked against a behavioral predictor.
// Depends on lcabl_pkg and the lca_binary_lifting RTL.
`timescale 1ns / 1ps

module tb_lca_binary_lifting;
    import lcabl_pkg::*;

    // Action code 3 is not in the package enum; the block must only acknowledge it.
    localparam logic [1:0] ACT_UNKNOWN = 2'd3;
    localparam int LONG_HOLD  = 400;
    localparam int ITEM_GOAL  = 1760;
    localparam int DRAIN_MAX  = 200000;

    typedef struct packed {
        logic [1:0] action;
        t_node      first;
        t_node      second;
        t_node      depth;
    } t_lca_item;

    typedef struct packed {
        t_node ancestor;
        logic  is_answer;
    } t_lca_result;

    // Holds its own copy of the parent/ancestor rows, depths and node count, and
    // the answers that the block still owes, oldest first.
    class lca_scoreboard;
        t_node         lift_rows [LEVELS][NODES];
        t_node         depth_mem [NODES];
        t_node         node_count;
        t_lca_result   answers_due [$];
        int            mismatch_count;

        function new();
            for (int lv = 0; lv < LEVELS; lv++)
                for (int n = 0; n < NODES; n++)
                    lift_rows[lv][n] = '0;
            for (int n = 0; n < NODES; n++)
                depth_mem[n] = '0;
            node_count = t_node'(1);
            mismatch_count = 0;
        endfunction

        function void set_node_count(t_node value);
            node_count = value;
        endfunction

        function void build_rows();
            for (int lv = 1; lv < LEVELS; lv++)
                for (int n = 1; n <= int'(node_count); n++)
                    lift_rows[lv][n] = lift_rows[lv-1][lift_rows[lv-1][n]];
        endfunction

        // Lift the deeper node to the other's depth, then climb both while their
        // ancestors differ. Stored data need not form a real tree.
        function t_node lowest_common(t_node a_in, t_node b_in);
            t_node a, b, ua, ub, swap;
            int    gap;
            a = a_in;
            b = b_in;
            if (depth_mem[a] > depth_mem[b]) begin
                swap = a;
                a = b;
                b = swap;
            end
            for (int lv = LEVELS - 1; lv >= 0; lv--) begin
                gap = int'(depth_mem[b]) - int'(depth_mem[a]);
                if (gap >= (1 << lv))
                    b = lift_rows[lv][b];
            end
            if (a == b)
                return a;
            for (int lv = LEVELS - 1; lv >= 0; lv--) begin
                ua = lift_rows[lv][a];
                ub = lift_rows[lv][b];
                if (ua != ub) begin
                    a = ua;
                    b = ub;
                end
            end
            return lift_rows[0][a];
        endfunction

        function void note_item(t_lca_item it);
            t_lca_result res;
            res.ancestor  = '0;
            res.is_answer = 1'b0;
            case (it.action)
                ACT_LOAD: begin
                    if (it.first != 0 && it.first <= node_count) begin
                        lift_rows[0][it.first] = it.second;
                        depth_mem[it.first]    = it.depth;
                    end
                end
                ACT_BUILD: build_rows();
                ACT_QUERY: begin
                    res.ancestor  = lowest_common(it.first, it.second);
                    res.is_answer = 1'b1;
                end
                default: ;
            endcase
            answers_due.insert(answers_due.size(), res);
        endfunction

        function void check_result(t_node ancestor, logic is_answer);
            t_lca_result want;
            if (answers_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: result ancestor=%0d is_answer=%0b, none outstanding",
                             ancestor, is_answer);
                return;
            end
            want = answers_due.pop_front();
            if (ancestor !== want.ancestor || is_answer !== want.is_answer) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: expected ancestor=%0d is_answer=%0b, got %0d %0b",
                             want.ancestor, want.is_answer, ancestor, is_answer);
            end
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic [1:0]          s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [0:0]          m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    t_node               cfg_data  = '0;

    lca_scoreboard sb = new();
    int  items_sent    = 0;
    bit  hold_request  = 1'b0;
    bit  hold_done     = 1'b0;

    lca_binary_lifting dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Results are taken at the rising edge; the ready comes from the sink below.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[FIELD_W-1:0], m_tuser[0]);
    end

    // Result sink: mostly ready, short and occasional long stalls, some fully open
    // stretches, and one long hold-off on request so the block backs up into its input.
    initial begin : result_sink
        int pick;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            pick = $urandom_range(0, 99);
            if (hold_request && !hold_done) begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_done = 1'b1;
                m_tready  = 1'b1;
            end else if (pick < 4) begin
                m_tready = 1'b1;
                repeat ($urandom_range(50, 200)) @(negedge clk);
            end else if (pick < 72) begin
                m_tready = 1'b1;
            end else if (pick < 97) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge clk);
            end else begin
                m_tready = 1'b0;
                repeat ($urandom_range(10, 40)) @(negedge clk);
            end
        end
    end

    function automatic t_lca_item make_item(logic [1:0] action, int first, int second,
                                            int depth);
        t_lca_item it;
        it.action = action;
        it.first  = t_node'(first);
        it.second = t_node'(second);
        it.depth  = t_node'(depth);
        return it;
    endfunction

    function automatic t_lca_item random_item();
        return make_item(2'($urandom_range(0, 3)), $urandom_range(0, NODES - 1),
                         $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1));
    endfunction

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Drops valid between items when n is nonzero; with n = 0 the next item follows back to back.
    task automatic sender_pause(input int n);
        if (n > 0) begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic send_item(input t_lca_item it, input bit burst);
        sender_pause(burst ? 0 : pick_gap());
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = it.action;
        s_tdata  = '0;
        s_tdata[FIELD_W-1:0]           = it.first;
        s_tdata[2*FIELD_W-1:FIELD_W]   = it.second;
        s_tdata[3*FIELD_W-1:2*FIELD_W] = it.depth;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_item(it);
        items_sent++;
    endtask

    // Stops offering items and waits for every outstanding answer, giving up at the limit.
    task automatic drain(input int limit);
        int waited;
        waited = 0;
        sender_pause(1);
        while (sb.answers_due.size() != 0 && waited < limit) begin
            @(posedge clk);
            waited++;
        end
        repeat (80) @(posedge clk);
    endtask

    task automatic write_node_count(input t_node value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_node_count(value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // One phase: set the node count, load a random tree (chain_bias percent of nodes
    // hang off the previous node, giving deep paths), build, then query. A few noise
    // items and re-loads after the build are mixed in.
    task automatic run_tree_phase(input t_node count, input int chain_bias,
                                  input int n_queries, input bit burst, input bit hold_here);
        t_node     par [NODES];
        t_node     dep [NODES];
        t_lca_item it;
        int        pick;
        int        a, b;
        drain(DRAIN_MAX);
        write_node_count(count);
        par[0] = '0;
        dep[0] = '0;
        for (int k = 1; k <= int'(count); k++) begin
            if (k == 1)
                par[k] = '0;
            else if ($urandom_range(0, 99) < chain_bias)
                par[k] = t_node'(k - 1);
            else
                par[k] = t_node'($urandom_range(1, k - 1));
            dep[k] = dep[par[k]] + 1'b1;
            if ($urandom_range(0, 99) < 4)
                send_item(random_item(), burst);
            send_item(make_item(ACT_LOAD, k, par[k], dep[k]), burst);
        end
        send_item(make_item(ACT_BUILD, 0, 0, 0), burst);
        if (hold_here)
            hold_request = 1'b1;
        for (int q = 0; q < n_queries; q++) begin
            pick = $urandom_range(0, 99);
            if (count != 0 && pick < 20) begin
                // Node against one of its own ancestors.
                b = $urandom_range(1, count);
                a = b;
                repeat ($urandom_range(0, 12)) a = par[a];
                it = ($urandom_range(0, 1) != 0) ? make_item(ACT_QUERY, a, b, 0)
                                                 : make_item(ACT_QUERY, b, a, 0);
            end else if (count != 0 && pick < 82) begin
                it = make_item(ACT_QUERY, $urandom_range(1, count), $urandom_range(1, count),
                               $urandom_range(0, NODES - 1));
            end else if (count != 0 && pick < 87) begin
                it = make_item(ACT_QUERY, 0, $urandom_range(1, count), 0);
            end else if (count != 0 && pick < 89) begin
                // Re-load after the build leaves the upper rows stale.
                a = $urandom_range(1, count);
                it = make_item(ACT_LOAD, a, $urandom_range(0, count),
                               $urandom_range(1, NODES - 1));
            end else if (pick < 94) begin
                it = random_item();
            end else begin
                it = make_item(ACT_QUERY, $urandom_range(0, NODES - 1),
                               $urandom_range(0, NODES - 1), 0);
            end
            send_item(it, 1'b0);
        end
    endtask

    initial begin : stimulus
        int    phase;
        t_node count;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset node count of one.
        send_item(make_item(ACT_QUERY, 0, 0, 0), 1'b0);
        send_item(make_item(ACT_LOAD, 1, 0, 1), 1'b0);
        // Beyond the node count, then node zero: both only acknowledged.
        send_item(make_item(ACT_LOAD, 2, 1, 2), 1'b0);
        send_item(make_item(ACT_LOAD, 0, NODES - 1, NODES - 1), 1'b0);
        // Query before any build reads the cleared upper rows.
        send_item(make_item(ACT_QUERY, 1, 2, 0), 1'b1);
        send_item(make_item(ACT_BUILD, 0, 0, 0), 1'b1);
        send_item(make_item(ACT_QUERY, 1, 1, 0), 1'b0);
        send_item(make_item(ACT_QUERY, 1, 0, NODES - 1), 1'b0);
        send_item(make_item(ACT_QUERY, NODES - 1, NODES - 1, NODES - 1), 1'b0);
        send_item(make_item(ACT_QUERY, NODES - 1, 0, 0), 1'b1);
        send_item(make_item(ACT_UNKNOWN, NODES - 1, NODES - 1, NODES - 1), 1'b1);
        send_item(make_item(ACT_UNKNOWN, 0, 0, 0), 1'b0);
        send_item(make_item(ACT_LOAD, NODES - 1, NODES - 1, NODES - 1), 1'b0);
        send_item(make_item(ACT_QUERY, 0, 1, 0), 1'b0);

        // Random phases: a zero count, the smallest real tree with the long sink
        // hold-off, the full-size deep tree once, then mostly small trees.
        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            case (phase)
                0: run_tree_phase(t_node'(0), 50, 15, 1'b0, 1'b0);
                1: run_tree_phase(t_node'(2), 50, 40, 1'b0, 1'b1);
                2: run_tree_phase(t_node'(NODES - 1), 92, 90, 1'b1, 1'b0);
                default: begin
                    if ($urandom_range(0, 99) < 10)
                        count = t_node'($urandom_range(100, 250));
                    else
                        count = t_node'($urandom_range(3, 48));
                    run_tree_phase(count, $urandom_range(20, 90), $urandom_range(15, 40),
                                   ($urandom_range(0, 3) == 0), 1'b0);
                end
            endcase
            phase++;
        end

        drain(DRAIN_MAX);
        if (sb.mismatch_count == 0 && sb.answers_due.size() == 0)
            $display("lca_binary_lifting verification clean");
        else
            $display("lca_binary_lifting verification failed");
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial begin : watchdog
        #10_000_000;
        $display("lca_binary_lifting verification failed");
        $finish;
    end

endmodule
